>>> src/pse_pkg.sv
// pse_pkg: constants, codes and types shared by the prime sieve engine.
// No dependencies; imported by pse_ram users and the top level.
`timescale 1ns / 1ps

package pse_pkg;

   localparam int MAX_NUMBER  = 65535;
   localparam int MAP_DEPTH   = MAX_NUMBER + 1;
   localparam int ADDR_W      = $clog2(MAP_DEPTH);

   localparam int NUM_W       = 16;
   localparam int COUNT_W     = 13;
   localparam int STATUS_W    = 2;

   localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(1000);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ADDR_W:0]   wide_addr_type;

   typedef enum logic {
      KIND_BUILD = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_BUILT = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FILL  = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_MARK  = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_QREAD = 7'b1000000
   } state_type;

endpackage

>>> src/pse_ram.sv
// pse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pse_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/prime_sieve_engine.sv
// prime_sieve_engine: sieve of Eratosthenes over a one-bit primality map.
// Depends on pse_pkg and pse_ram.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------
//  request   req_kind, req_number                    start && !busy
//  response  rsp_is_prime, rsp_status, rsp_prime_count  rsp_valid, one cycle
//  csr       csr_write_data (sieve_limit)            csr_write_en
//
// Query: an error status goes straight into the response registers; else one
// registered map read feeds ST_QREAD. Build, limit L: fill 0..L, then read each
// candidate p in 2..L and, for each prime p, mark its multiples from 2p up to L,
// then finish in ST_DONE; all of it runs through one shared adder and the
// single write port of the map. busy stays high from the cycle after start and
// falls as the response appears on the ports; an error-status query never
// raises it. Synchronous reset clears control state and loads LIMIT_RESET into
// the limit CSR; the map holds no reset value. The response cannot be stalled.
`timescale 1ns / 1ps

module prime_sieve_engine
   import pse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [NUM_W-1:0]    req_number,
   output logic                rsp_valid,
   output logic                rsp_is_prime,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_prime_count,
   input  logic                csr_write_en,
   input  logic [NUM_W-1:0]    csr_write_data
);

   state_type           state_ff, state_in;
   logic [NUM_W-1:0]    csr_limit_ff;
   logic                map_valid_ff, map_valid_in;
   addr_type            lim_ff, lim_in;
   addr_type            idx_ff, idx_in;
   addr_type            p_ff, p_in;
   wide_addr_type       j_ff, j_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_is_prime_ff, rsp_is_prime_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   wide_addr_type       add_a, add_b, add_sum;
   addr_type            build_lim;
   logic                accept;
   logic                j_in_range;

   logic                wr_en, rd_en, wr_data, rd_data;
   addr_type            wr_addr, rd_addr;

   pse_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign build_lim  = (32'(csr_limit_ff) > 32'(MAX_NUMBER)) ? ADDR_W'(MAX_NUMBER)
                                                             : ADDR_W'(csr_limit_ff);
   assign j_in_range = (j_ff <= {1'b0, lim_ff});

   // shared adder: fill index step, 2p, j+p, next candidate
   always_comb begin
      add_a = '0;
      add_b = '0;
      case (state_ff)
         ST_FILL: begin
            add_a = {1'b0, idx_ff};
            add_b = (ADDR_W+1)'(1);
         end
         ST_CHECK: begin
            add_a = {1'b0, p_ff};
            if (rd_data) begin
               add_b = {1'b0, p_ff};
            end else begin
               add_b = (ADDR_W+1)'(1);
            end
         end
         ST_MARK: begin
            if (j_in_range) begin
               add_a = j_ff;
               add_b = {1'b0, p_ff};
            end else begin
               add_a = {1'b0, p_ff};
               add_b = (ADDR_W+1)'(1);
            end
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   always_comb begin
      state_in        = state_ff;
      map_valid_in    = map_valid_ff;
      lim_in          = lim_ff;
      idx_in          = idx_ff;
      p_in            = p_ff;
      j_in            = j_ff;
      count_in        = count_ff;
      rsp_valid_in    = 1'b0;
      rsp_is_prime_in = rsp_is_prime_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_count_in    = rsp_count_ff;
      wr_en           = 1'b0;
      wr_addr         = idx_ff;
      wr_data         = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = p_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_BUILD) begin
                  lim_in   = build_lim;
                  idx_in   = '0;
                  count_in = '0;
                  state_in = ST_FILL;
               end else if (!map_valid_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
                  rsp_status_in   = STATUS_NOT_BUILT;
                  rsp_count_in    = '0;
               end else if (32'(req_number) > 32'(lim_ff)) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
                  rsp_status_in   = STATUS_RANGE;
                  rsp_count_in    = '0;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(req_number);
                  state_in = ST_QREAD;
               end
            end
         end
         ST_QREAD: begin
            rsp_valid_in    = 1'b1;
            rsp_is_prime_in = rd_data;
            rsp_status_in   = STATUS_OK;
            rsp_count_in    = '0;
            state_in        = ST_IDLE;
         end
         ST_FILL: begin
            // 0 and 1 are written as non-prime, all others as candidates
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = (32'(idx_ff) >= 32'd2);
            idx_in  = add_sum[ADDR_W-1:0];
            if (idx_ff == lim_ff) begin
               if (32'(lim_ff) < 32'd2) begin
                  state_in = ST_DONE;
               end else begin
                  p_in     = ADDR_W'(2);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_en    = 1'b1;
            rd_addr  = p_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_data) begin
               count_in = count_ff + COUNT_W'(1);
               j_in     = add_sum;
               state_in = ST_MARK;
            end else if (p_ff == lim_ff) begin
               state_in = ST_DONE;
            end else begin
               p_in     = add_sum[ADDR_W-1:0];
               state_in = ST_SCAN;
            end
         end
         ST_MARK: begin
            if (j_in_range) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[ADDR_W-1:0];
               wr_data = 1'b0;
               j_in    = add_sum;
            end else if (p_ff == lim_ff) begin
               state_in = ST_DONE;
            end else begin
               p_in     = add_sum[ADDR_W-1:0];
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            map_valid_in    = 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_is_prime_in = 1'b0;
            rsp_status_in   = STATUS_OK;
            rsp_count_in    = count_ff;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_valid_ff <= 1'b0;
         lim_ff       <= '0;
         csr_limit_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_valid_ff <= map_valid_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            csr_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      p_ff            <= p_in;
      j_ff            <= j_in;
      count_ff        <= count_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_prime    = rsp_is_prime_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_prime_count = rsp_count_ff;

endmodule
